>>> rtl/rtp_pkg.sv
// Shared types, character codes and the frequency table for the RTTTL tone parser.
// No dependencies; used by every module of the block.
package rtp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NUM_W    = 16;
    localparam int unsigned WHOLE_W  = 18;
    localparam int unsigned LEN_W    = 19;
    localparam int unsigned TONE_W   = 12;
    localparam int unsigned GAP_W    = 8;
    localparam int unsigned OCT_W    = 3;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [WHOLE_W-1:0] WHOLE_MS_NUM = WHOLE_W'(240000);
    localparam logic [NUM_W-1:0]   SAT_MAX      = 16'hFFFF;

    localparam logic [NUM_W-1:0] RST_DURATION = 16'd4;
    localparam logic [OCT_W-1:0] RST_OCTAVE   = 3'd6;
    localparam logic [NUM_W-1:0] RST_BPM      = 16'd63;
    localparam logic [GAP_W-1:0] RST_GAP      = 8'd30;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BPM      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 4'd3;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_DUR  = 2'd1;
    localparam logic [1:0] KEY_OCT  = 2'd2;
    localparam logic [1:0] KEY_BPM  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
    localparam logic [BYTE_W-1:0] CH_4     = 8'h34;
    localparam logic [BYTE_W-1:0] CH_7     = 8'h37;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LC_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LC_D  = 8'h64;
    localparam logic [BYTE_W-1:0] CH_LC_O  = 8'h6F;

    localparam int unsigned FL_SHARP = 0;
    localparam int unsigned FL_DOT   = 1;
    localparam int unsigned FL_REST  = 2;
    localparam int unsigned FL_VALID = 3;

    typedef enum logic [3:0] {
        PH_NAME     = 4'd0,
        PH_HDR_IDLE = 4'd1,
        PH_HDR_KEY  = 4'd2,
        PH_HDR_NUM  = 4'd3,
        PH_NOTE     = 4'd4,
        PH_NOTE_DUR = 4'd5,
        PH_SHARP    = 4'd6,
        PH_DOT1     = 4'd7,
        PH_OCT      = 4'd8,
        PH_DOT2     = 4'd9,
        PH_COMMA    = 4'd10,
        PH_DONE     = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_DIV  = 2'd2,
        S_OUT  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic store_len;
        logic store_whole;
    } rtp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic len_pend;
        logic div_done;
    } rtp_status_t;

    localparam logic [TONE_W-1:0] FREQ_TAB [96] = '{
        12'd16,   12'd17,   12'd18,   12'd19,   12'd21,   12'd22,
        12'd23,   12'd24,   12'd26,   12'd27,   12'd29,   12'd31,
        12'd33,   12'd35,   12'd37,   12'd39,   12'd41,   12'd44,
        12'd46,   12'd49,   12'd52,   12'd55,   12'd58,   12'd62,
        12'd65,   12'd69,   12'd73,   12'd78,   12'd82,   12'd87,
        12'd92,   12'd98,   12'd104,  12'd110,  12'd117,  12'd123,
        12'd131,  12'd139,  12'd147,  12'd156,  12'd165,  12'd175,
        12'd185,  12'd196,  12'd208,  12'd220,  12'd233,  12'd247,
        12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
        12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494,
        12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
        12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988,
        12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
        12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976,
        12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
        12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951
    };

    function automatic logic [TONE_W-1:0] freq_lookup(input logic [OCT_W-1:0] oct,
                                                      input logic [3:0] semi);
        logic [6:0] idx;
        idx = 7'(oct) * 7'd12 + 7'(semi);
        return FREQ_TAB[idx];
    endfunction

endpackage

>>> rtl/rtp_div.sv
// Restoring divider, one quotient bit per cycle, for the whole-note and note lengths.
// Depends on rtp_pkg.
module rtp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rtp_pkg::WHOLE_W-1:0] dividend,
    input  logic [rtp_pkg::NUM_W-1:0]   divisor,
    output logic [rtp_pkg::WHOLE_W-1:0] quotient,
    output logic                        done
);
    import rtp_pkg::*;

    logic [WHOLE_W-1:0]   quo_reg, quo_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_W:0]       shifted;
    logic                 ge;

    assign shifted  = {rem_reg, quo_reg[WHOLE_W-1]};
    assign ge       = shifted >= {1'b0, dsr_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(WHOLE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? NUM_W'(shifted - {1'b0, dsr_reg}) : shifted[NUM_W-1:0];
            quo_next = {quo_reg[WHOLE_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

>>> rtl/rtp_ctrl.sv
// Sequencing state machine: byte transfer, parse step, division wait, result transfer.
// Depends on rtp_pkg.
module rtp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rtp_pkg::rtp_status_t status,
    output rtp_pkg::rtp_cmd_t    cmd
);
    import rtp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EVAL;
            S_EVAL: state_next = status.need_div ? S_DIV : S_IDLE;
            S_DIV:
                if (status.div_done) state_next = status.len_pend ? S_OUT : S_IDLE;
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        out_valid = state_reg == S_OUT;
        cmd.load        = (state_reg == S_IDLE) && in_valid;
        cmd.eval        = state_reg == S_EVAL;
        cmd.div_start   = (state_reg == S_EVAL) && status.need_div;
        cmd.store_len   = (state_reg == S_DIV) && status.div_done && status.len_pend;
        cmd.store_whole = (state_reg == S_DIV) && status.div_done && !status.len_pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/rtp_datapath.sv
// Parser state, configuration registers, note decode and result registers.
// Depends on rtp_pkg and rtp_div.
module rtp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rtp_pkg::rtp_cmd_t             cmd,
    output rtp_pkg::rtp_status_t          status,
    input  logic [rtp_pkg::BYTE_W-1:0]    text_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtp_pkg::CFG_DAT_W-1:0] cfg_data,
    output logic                          is_rest,
    output logic [rtp_pkg::TONE_W-1:0]    tone_hz,
    output logic [rtp_pkg::LEN_W-1:0]     length_ms,
    output logic [rtp_pkg::GAP_W-1:0]     gap_ms
);
    import rtp_pkg::*;

    logic [NUM_W-1:0]   dflt_dur_reg, dflt_bpm_reg;
    logic [OCT_W-1:0]   dflt_oct_reg;
    logic [GAP_W-1:0]   gap_cfg_reg;

    logic [BYTE_W-1:0]  byte_reg;
    phase_t             ph_reg, ph_next;
    logic [1:0]         key_reg, key_next;
    logic [NUM_W-1:0]   acc_reg, acc_next;
    logic [NUM_W-1:0]   tdur_reg, tdur_next, toct_reg, toct_next, tbpm_reg, tbpm_next;
    logic [WHOLE_W-1:0] whole_reg;
    logic [NUM_W-1:0]   ndiv_reg, ndiv_next;
    logic [3:0]         semi_reg, semi_next;
    logic [3:0]         flags_reg, flags_next;
    logic [NUM_W-1:0]   noct_reg, noct_next;
    logic               len_pend_reg;

    logic               rest_reg, dot_reg;
    logic [TONE_W-1:0]  tone_reg, tone_snap;
    logic [GAP_W-1:0]   gap_reg;
    logic [LEN_W-1:0]   len_reg;

    logic               do_idle, do_note, do_letter, fin, whole_div;
    logic               is_digit, is_nz_digit;
    logic [19:0]        acc_wide;
    logic [NUM_W-1:0]   acc_sat;
    logic [4:0]         semi_sh;
    logic [NUM_W:0]     oct_sh;
    logic [OCT_W-1:0]   oct_cl;
    logic [3:0]         semi_fix;
    logic               m_sh, m_d1, m_oc, m_d2, m_cm;
    logic [WHOLE_W-1:0] div_dividend, quotient;
    logic [NUM_W-1:0]   div_divisor;
    logic               div_done;
    logic [LEN_W-1:0]   len_sum;

    assign cfg_ready = 1'b1;

    assign is_digit    = (byte_reg >= CH_0) && (byte_reg <= CH_9);
    assign is_nz_digit = (byte_reg >= CH_1) && (byte_reg <= CH_9);
    assign acc_wide    = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                       + 20'(byte_reg - CH_0);
    assign acc_sat     = (acc_wide > 20'(SAT_MAX)) ? SAT_MAX : acc_wide[NUM_W-1:0];

    assign m_sh = (ph_reg == PH_SHARP) && (byte_reg == CH_HASH);
    assign m_d1 = (ph_reg <= PH_DOT1) && (byte_reg == CH_DOT);
    assign m_oc = (ph_reg <= PH_OCT) && (byte_reg >= CH_4) && (byte_reg <= CH_7);
    assign m_d2 = (ph_reg <= PH_DOT2) && (byte_reg == CH_DOT);
    assign m_cm = byte_reg == CH_COMMA;

    // frequency of the pending note; sharp B moves to C one octave up
    always_comb
    begin
        semi_sh = 5'(semi_reg) + 5'(flags_reg[FL_SHARP]);
        oct_sh  = {1'b0, noct_reg};
        semi_fix = semi_sh[3:0];
        if (semi_sh > 5'd11)
        begin
            semi_fix = 4'(semi_sh - 5'd12);
            oct_sh   = {1'b0, noct_reg} + 1'b1;
        end
        oct_cl    = (oct_sh > (NUM_W+1)'(7)) ? OCT_W'(7) : oct_sh[OCT_W-1:0];
        tone_snap = flags_reg[FL_REST] ? '0 : freq_lookup(oct_cl, semi_fix);
    end

    always_comb
    begin
        ph_next    = ph_reg;
        key_next   = key_reg;
        acc_next   = acc_reg;
        tdur_next  = tdur_reg;
        toct_next  = toct_reg;
        tbpm_next  = tbpm_reg;
        ndiv_next  = ndiv_reg;
        semi_next  = semi_reg;
        flags_next = flags_reg;
        noct_next  = noct_reg;
        do_idle    = 1'b0;
        do_note    = 1'b0;
        do_letter  = 1'b0;
        fin        = 1'b0;
        whole_div  = 1'b0;

        if (byte_reg == CH_NUL)
        begin
            fin        = (ph_reg >= PH_SHARP) && (ph_reg <= PH_COMMA);
            ph_next    = PH_NAME;
            key_next   = KEY_NONE;
            acc_next   = '0;
            tdur_next  = dflt_dur_reg;
            toct_next  = NUM_W'(dflt_oct_reg);
            tbpm_next  = dflt_bpm_reg;
            ndiv_next  = '0;
            semi_next  = '0;
            flags_next = '0;
            noct_next  = '0;
        end
        else
        begin
            unique case (ph_reg)
                PH_NAME:
                    if (byte_reg == CH_COLON)
                    begin
                        tdur_next = dflt_dur_reg;
                        toct_next = NUM_W'(dflt_oct_reg);
                        tbpm_next = dflt_bpm_reg;
                        ph_next   = PH_HDR_IDLE;
                    end
                PH_HDR_IDLE:
                    do_idle = 1'b1;
                PH_HDR_KEY:
                    if (byte_reg == CH_EQ)
                    begin
                        acc_next = '0;
                        ph_next  = PH_HDR_NUM;
                    end
                    else
                        do_idle = 1'b1;
                PH_HDR_NUM:
                    if (is_digit)
                        acc_next = acc_sat;
                    else
                    begin
                        priority if (key_reg == KEY_DUR) tdur_next = acc_reg;
                        else if (key_reg == KEY_OCT) toct_next = acc_reg;
                        else tbpm_next = acc_reg;
                        do_idle = 1'b1;
                    end
                PH_NOTE:
                    do_note = 1'b1;
                PH_NOTE_DUR:
                    if (is_digit)
                        acc_next = acc_sat;
                    else
                    begin
                        ndiv_next = acc_reg;
                        do_letter = 1'b1;
                    end
                PH_SHARP, PH_DOT1, PH_OCT, PH_DOT2, PH_COMMA:
                    priority if (m_sh)
                    begin
                        flags_next[FL_SHARP] = 1'b1;
                        ph_next = PH_DOT1;
                    end
                    else if (m_d1)
                    begin
                        flags_next[FL_DOT] = 1'b1;
                        ph_next = PH_OCT;
                    end
                    else if (m_oc)
                    begin
                        noct_next = NUM_W'(byte_reg - CH_0);
                        ph_next   = PH_DOT2;
                    end
                    else if (m_d2)
                    begin
                        flags_next[FL_DOT] = 1'b1;
                        ph_next = PH_COMMA;
                    end
                    else if (m_cm)
                    begin
                        fin     = 1'b1;
                        ph_next = PH_NOTE;
                    end
                    else
                    begin
                        fin     = 1'b1;
                        ph_next = PH_NOTE;
                        do_note = 1'b1;
                    end
                default: ;
            endcase

            if (do_idle)
            begin
                ph_next = PH_HDR_IDLE;
                priority if (byte_reg == CH_COLON)
                begin
                    whole_div = 1'b1;
                    ph_next   = PH_NOTE;
                end
                else if (byte_reg == CH_LC_D)
                begin
                    key_next = KEY_DUR;
                    ph_next  = PH_HDR_KEY;
                end
                else if (byte_reg == CH_LC_O)
                begin
                    key_next = KEY_OCT;
                    ph_next  = PH_HDR_KEY;
                end
                else if (byte_reg == CH_LC_B)
                begin
                    key_next = KEY_BPM;
                    ph_next  = PH_HDR_KEY;
                end
            end

            if (do_note)
            begin
                priority if (byte_reg == CH_SPACE)
                    ph_next = PH_NOTE;
                else if (byte_reg == CH_CR || byte_reg == CH_LF)
                    ph_next = PH_DONE;
                else if (is_nz_digit)
                begin
                    acc_next = NUM_W'(byte_reg - CH_0);
                    ph_next  = PH_NOTE_DUR;
                end
                else
                begin
                    ndiv_next = tdur_reg;
                    do_letter = 1'b1;
                end
            end

            if (do_letter)
            begin
                flags_next = '0;
                semi_next  = '0;
                unique case (byte_reg | 8'h20)
                    8'h63: begin semi_next = 4'd0;  flags_next[FL_VALID] = 1'b1; end
                    8'h64: begin semi_next = 4'd2;  flags_next[FL_VALID] = 1'b1; end
                    8'h65: begin semi_next = 4'd4;  flags_next[FL_VALID] = 1'b1; end
                    8'h66: begin semi_next = 4'd5;  flags_next[FL_VALID] = 1'b1; end
                    8'h67: begin semi_next = 4'd7;  flags_next[FL_VALID] = 1'b1; end
                    8'h61: begin semi_next = 4'd9;  flags_next[FL_VALID] = 1'b1; end
                    8'h62: begin semi_next = 4'd11; flags_next[FL_VALID] = 1'b1; end
                    8'h70: flags_next[FL_REST] = 1'b1;
                    default: ;
                endcase
                noct_next = toct_reg;
                ph_next   = PH_SHARP;
            end
        end
    end

    assign status.len_pend = len_pend_reg;
    assign status.div_done = div_done;
    assign status.need_div = whole_div || (fin && (flags_reg[FL_REST] || flags_reg[FL_VALID]));

    always_comb
    begin
        if (whole_div)
        begin
            div_dividend = WHOLE_MS_NUM;
            div_divisor  = (tbpm_next == '0) ? NUM_W'(1) : tbpm_next;
        end
        else
        begin
            div_dividend = whole_reg;
            div_divisor  = (ndiv_reg == '0) ? NUM_W'(1) : ndiv_reg;
        end
    end

    rtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign len_sum = {1'b0, quotient}
                   + (dot_reg ? {2'b0, quotient[WHOLE_W-1:1]} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_dur_reg <= RST_DURATION;
            dflt_oct_reg <= RST_OCTAVE;
            dflt_bpm_reg <= RST_BPM;
            gap_cfg_reg  <= RST_GAP;
            ph_reg       <= PH_NAME;
            key_reg      <= KEY_NONE;
            acc_reg      <= '0;
            tdur_reg     <= RST_DURATION;
            toct_reg     <= NUM_W'(RST_OCTAVE);
            tbpm_reg     <= RST_BPM;
            whole_reg    <= '0;
            ndiv_reg     <= '0;
            semi_reg     <= '0;
            flags_reg    <= '0;
            noct_reg     <= '0;
            len_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_DURATION: dflt_dur_reg <= cfg_data;
                    REG_OCTAVE:   dflt_oct_reg <= cfg_data[OCT_W-1:0];
                    REG_BPM:      dflt_bpm_reg <= cfg_data;
                    REG_GAP:      gap_cfg_reg  <= cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.eval)
            begin
                ph_reg       <= ph_next;
                key_reg      <= key_next;
                acc_reg      <= acc_next;
                tdur_reg     <= tdur_next;
                toct_reg     <= toct_next;
                tbpm_reg     <= tbpm_next;
                ndiv_reg     <= ndiv_next;
                semi_reg     <= semi_next;
                flags_reg    <= flags_next;
                noct_reg     <= noct_next;
                len_pend_reg <= !whole_div;
                if (byte_reg == CH_NUL)
                    whole_reg <= '0;
            end
            if (cmd.store_whole)
                whole_reg <= quotient;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= text_byte;
        if (cmd.eval)
        begin
            rest_reg <= flags_reg[FL_REST];
            dot_reg  <= flags_reg[FL_DOT];
            tone_reg <= tone_snap;
            gap_reg  <= flags_reg[FL_REST] ? '0 : gap_cfg_reg;
        end
        if (cmd.store_len)
            len_reg <= len_sum;
    end

    assign is_rest   = rest_reg;
    assign tone_hz   = tone_reg;
    assign length_ms = len_reg;
    assign gap_ms    = gap_reg;

endmodule

>>> rtl/rtttl_tone_parser_core.sv
// RTTTL ringtone parser top level: controller and datapath.
// Depends on rtp_pkg, rtp_ctrl, rtp_datapath (and rtp_div through it).
//
// Usage: feed the ringtone text one byte per transfer on in_valid/in_ready
// (text_byte). Each completed note yields one transfer on out_valid/out_ready
// carrying is_rest, tone_hz, length_ms and gap_ms; bad note letters yield none.
// A zero byte flushes a pending note and restarts the parser.
// Defaults are written on cfg_valid/cfg_ready (always ready): cfg_index 0 default
// duration, 1 default octave, 2 default bpm, 3 gap after tones; other indexes
// are ignored. Write them only while the block is idle.
// Flow: one byte at a time. A byte that yields no result and needs no
// division goes back to idle after its parse step, with no division wait. The
// ':' ending the header and any byte that completes a valid note or rest start
// the restoring divider; when it is done the header returns to idle and a note
// goes to the output register. The result stays there and no new byte is
// taken until it is transferred, so a stalled receiver stalls the input. Reset
// restores the default registers (4, 6, 63, 30) and the parser to the name section.
module rtttl_tone_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rtp_pkg::BYTE_W-1:0]    text_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_rest,
    output logic [rtp_pkg::TONE_W-1:0]    tone_hz,
    output logic [rtp_pkg::LEN_W-1:0]     length_ms,
    output logic [rtp_pkg::GAP_W-1:0]     gap_ms,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtp_pkg::CFG_DAT_W-1:0] cfg_data
);
    import rtp_pkg::*;

    rtp_cmd_t    cmd;
    rtp_status_t status;

    rtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rtp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .text_byte (text_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .is_rest   (is_rest),
        .tone_hz   (tone_hz),
        .length_ms (length_ms),
        .gap_ms    (gap_ms)
    );

endmodule
